// ----- rtl/rdc_pkg.sv -----
// Package for the range distinct count block: field widths, default sizes,
// command codes and the sequencer state type. No dependencies.
// Used by the top level and its port checker.
package rdc_pkg;

  localparam int unsigned ARRAY_DEPTH_DEF = 1024;
  localparam int unsigned VALUE_BITS_DEF  = 16;

  localparam int unsigned POS_BITS   = 10;
  localparam int unsigned NEWV_BITS  = 16;
  localparam int unsigned COUNT_BITS = 11;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = 11'd1024;

  typedef enum logic {
    CMD_SET   = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_MARK,
    ST_CLEAR,
    ST_DONE
  } state_e;

endpackage

// ----- rtl/range_distinct_count_with_updates.sv -----
// Range distinct count with point updates.
//
// Input channel (in_valid_i/in_ready_o) carries one word per item: a set
// (command 0) writes new_value_i at position_i; a query (command 1) asks how
// many distinct values lie in positions position_i..right_end_i inclusive.
// Output channel (out_valid_o/out_ready_i) returns one distinct_count_o word
// per query; sets return nothing.
// A set is taken in the idle state, so the block is ready again right after it.
// A query over L positions runs two passes: one pass of the value RAM marks
// each value in a seen bitmap RAM (one position per cycle, through the
// registered value read and then the registered bitmap read), a second
// pass clears the marks. A reversed or empty range skips both passes and
// returns 0. Right ends past the array saturate to the last position.
// After reset the seen bitmap is swept to zero, all 2^VALUE_BITS entries
// (65536 by default), with in_ready_o low. The result sits in an output
// register; a stalled receiver holds it, new items are still taken, and a
// second query finishing meanwhile waits until the first word is taken.
// Depends on rdc_pkg and rdc_ram.
module range_distinct_count_with_updates #(
  parameter int unsigned ARRAY_DEPTH = rdc_pkg::ARRAY_DEPTH_DEF,
  parameter int unsigned VALUE_BITS  = rdc_pkg::VALUE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            command_i,
  input  logic [rdc_pkg::POS_BITS-1:0]    position_i,
  input  logic [rdc_pkg::POS_BITS-1:0]    right_end_i,
  input  logic [rdc_pkg::NEWV_BITS-1:0]   new_value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [rdc_pkg::COUNT_BITS-1:0]  distinct_count_o
);

  localparam int unsigned AW       = $clog2(ARRAY_DEPTH);
  localparam int unsigned MDEPTH   = 1 << VALUE_BITS;
  localparam int unsigned PB       = rdc_pkg::POS_BITS;
  localparam int unsigned CB       = rdc_pkg::COUNT_BITS;
  localparam logic [31:0] DEPTH32  = 32'(ARRAY_DEPTH);

  rdc_pkg::state_e state_q, state_d;

  logic [VALUE_BITS-1:0] init_ptr_q, init_ptr_d;
  logic [PB-1:0]         ptr_q, ptr_d;
  logic [PB-1:0]         left_q, left_d;
  logic [PB-1:0]         right_q, right_d;
  logic                  iss_q, iss_d;
  logic                  s1_vld_q, s1_vld_d;
  logic                  s2_vld_q, s2_vld_d;
  logic [VALUE_BITS-1:0] s2_val_q, s2_val_d;
  logic                  wr_vld_q, wr_vld_d;
  logic [VALUE_BITS-1:0] wr_val_q, wr_val_d;
  logic [CB-1:0]         cnt_q, cnt_d;
  logic                  out_valid_q, out_valid_d;
  logic [CB-1:0]         out_cnt_q, out_cnt_d;

  logic                  vram_we;
  logic [AW-1:0]         vram_waddr;
  logic [VALUE_BITS-1:0] vram_wdata;
  logic [AW-1:0]         vram_raddr;
  logic [VALUE_BITS-1:0] vram_rdata;

  logic                  mram_we;
  logic [VALUE_BITS-1:0] mram_waddr;
  logic [0:0]            mram_wdata;
  logic [VALUE_BITS-1:0] mram_raddr;
  logic [0:0]            mram_rdata;

  logic          in_fire;
  logic          is_query;
  logic [PB-1:0] right_sat;
  logic          query_empty;
  logic          set_in_range;
  logic          mark_hit;
  logic          mark_done;
  logic          clear_done;
  logic          out_load;

  assign in_ready_o   = (state_q == rdc_pkg::ST_IDLE);
  assign in_fire      = in_valid_i & in_ready_o;
  assign is_query     = (command_i == rdc_pkg::CMD_QUERY);
  assign right_sat    = (32'(right_end_i) >= DEPTH32) ? PB'(DEPTH32 - 32'd1) : right_end_i;
  assign query_empty  = (position_i > right_sat);
  assign set_in_range = (32'(position_i) < DEPTH32);

  // The previous write, now in wr_val_q, raced the mark read; forward it.
  assign mark_hit   = mram_rdata[0] | (wr_vld_q & (wr_val_q == s2_val_q));
  assign mark_done  = ~iss_q & ~s1_vld_q & ~s2_vld_q;
  assign clear_done = ~iss_q & ~s1_vld_q;
  assign out_load   = (state_q == rdc_pkg::ST_DONE) & (~out_valid_q | out_ready_i);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rdc_pkg::ST_INIT: begin
        if (init_ptr_q == '1) state_d = rdc_pkg::ST_IDLE;
      end
      rdc_pkg::ST_IDLE: begin
        if (in_fire && is_query) begin
          state_d = query_empty ? rdc_pkg::ST_DONE : rdc_pkg::ST_MARK;
        end
      end
      rdc_pkg::ST_MARK: begin
        if (mark_done) state_d = rdc_pkg::ST_CLEAR;
      end
      rdc_pkg::ST_CLEAR: begin
        if (clear_done) state_d = rdc_pkg::ST_DONE;
      end
      rdc_pkg::ST_DONE: begin
        if (out_load) state_d = rdc_pkg::ST_IDLE;
      end
      default: state_d = rdc_pkg::ST_INIT;
    endcase
  end

  // Walk engine and RAM control
  always_comb begin
    init_ptr_d = init_ptr_q;
    ptr_d      = ptr_q;
    left_d     = left_q;
    right_d    = right_q;
    iss_d      = iss_q;
    s1_vld_d   = 1'b0;
    s2_vld_d   = 1'b0;
    s2_val_d   = s2_val_q;
    wr_vld_d   = 1'b0;
    wr_val_d   = wr_val_q;
    cnt_d      = cnt_q;
    out_cnt_d  = out_cnt_q;

    vram_we    = 1'b0;
    vram_waddr = AW'(position_i);
    vram_wdata = VALUE_BITS'(new_value_i);
    vram_raddr = AW'(ptr_q);

    mram_we    = 1'b0;
    mram_waddr = init_ptr_q;
    mram_wdata = 1'b0;
    mram_raddr = vram_rdata;

    case (state_q)
      rdc_pkg::ST_INIT: begin
        mram_we    = 1'b1;
        init_ptr_d = init_ptr_q + 1'b1;
      end
      rdc_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (is_query) begin
            left_d  = position_i;
            right_d = right_sat;
            ptr_d   = position_i;
            iss_d   = ~query_empty;
            cnt_d   = '0;
          end else begin
            vram_we = set_in_range;
          end
        end
      end
      rdc_pkg::ST_MARK: begin
        if (iss_q) begin
          ptr_d = ptr_q + 1'b1;
          if (ptr_q == right_q) iss_d = 1'b0;
        end
        s1_vld_d = iss_q;
        s2_vld_d = s1_vld_q;
        s2_val_d = vram_rdata;
        wr_vld_d = s2_vld_q;
        wr_val_d = s2_val_q;
        if (s2_vld_q) begin
          mram_we    = 1'b1;
          mram_waddr = s2_val_q;
          mram_wdata = 1'b1;
          if (!mark_hit) cnt_d = cnt_q + 1'b1;
        end
        // restart the walk from the left end to clear the marks
        if (mark_done) begin
          iss_d = 1'b1;
          ptr_d = left_q;
        end
      end
      rdc_pkg::ST_CLEAR: begin
        if (iss_q) begin
          ptr_d = ptr_q + 1'b1;
          if (ptr_q == right_q) iss_d = 1'b0;
        end
        s1_vld_d = iss_q;
        if (s1_vld_q) begin
          mram_we    = 1'b1;
          mram_waddr = vram_rdata;
          mram_wdata = 1'b0;
        end
      end
      rdc_pkg::ST_DONE: begin
        if (out_load) out_cnt_d = cnt_q;
      end
      default: ;
    endcase
  end

  assign out_valid_d = out_load | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rdc_pkg::ST_INIT;
      init_ptr_q  <= '0;
      iss_q       <= 1'b0;
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      wr_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_ptr_q  <= init_ptr_d;
      iss_q       <= iss_d;
      s1_vld_q    <= s1_vld_d;
      s2_vld_q    <= s2_vld_d;
      wr_vld_q    <= wr_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q     <= ptr_d;
    left_q    <= left_d;
    right_q   <= right_d;
    s2_val_q  <= s2_val_d;
    wr_val_q  <= wr_val_d;
    cnt_q     <= cnt_d;
    out_cnt_q <= out_cnt_d;
  end

  assign out_valid_o      = out_valid_q;
  assign distinct_count_o = out_cnt_q;

  rdc_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (ARRAY_DEPTH)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (vram_we),
    .waddr_i (vram_waddr),
    .wdata_i (vram_wdata),
    .raddr_i (vram_raddr),
    .rdata_o (vram_rdata)
  );

  rdc_ram #(
    .WIDTH (1),
    .DEPTH (MDEPTH)
  ) u_mark_ram (
    .clk_i   (clk_i),
    .we_i    (mram_we),
    .waddr_i (mram_waddr),
    .wdata_i (mram_wdata),
    .raddr_i (mram_raddr),
    .rdata_o (mram_rdata)
  );

endmodule

// ----- rtl/rdc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Read-first: a read at the address being written returns the old word.
// No dependencies.
module rdc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

endmodule

// ----- rtl/rdc_checker.sv -----
// Port-level checker for the range distinct count block, bound to the top.
// Depends on rdc_pkg.
// Watches the handshakes and the sequencing a query imposes on in_ready_o.
module rdc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           command_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [rdc_pkg::COUNT_BITS-1:0] distinct_count_o
);

  logic in_fire;
  assign in_fire = in_valid_i & in_ready_o;

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(distinct_count_o))
    else $error("result word changed while stalled");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> distinct_count_o <= rdc_pkg::COUNT_MAX)
    else $error("distinct count beyond range size");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && command_i == rdc_pkg::CMD_QUERY |=> !in_ready_o)
    else $error("ready right after a query");

  a_set_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && command_i == rdc_pkg::CMD_SET |=> in_ready_o)
    else $error("not ready right after a set");

endmodule

bind range_distinct_count_with_updates rdc_checker u_rdc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .command_i        (command_i),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .distinct_count_o (distinct_count_o)
);

// ----- verif/rdc_count_checker.sv -----
`timescale 1ns / 100ps
// Port checker for range_distinct_count_with_updates. It mirrors the value
// array from accepted set words, predicts one distinct count per query word
// and compares the returned words in order. Depends on rdc_pkg.
module rdc_count_checker #(
  parameter int unsigned ARRAY_DEPTH = rdc_pkg::ARRAY_DEPTH_DEF,
  parameter int unsigned VALUE_BITS  = rdc_pkg::VALUE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic                            command_i,
  input  logic [rdc_pkg::POS_BITS-1:0]    position_i,
  input  logic [rdc_pkg::POS_BITS-1:0]    right_end_i,
  input  logic [rdc_pkg::NEWV_BITS-1:0]   new_value_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [rdc_pkg::COUNT_BITS-1:0]  distinct_count_i,
  output int                              fail_count_o,
  output int                              pending_o,
  output int                              checked_o
);

  typedef struct {
    logic [rdc_pkg::COUNT_BITS-1:0] count;
    int unsigned                    left;
    int unsigned                    right;
  } count_expect_t;

  logic [VALUE_BITS-1:0] shadow_store [ARRAY_DEPTH];
  bit                    seen_mark [1 << VALUE_BITS];
  count_expect_t         expected_counts [$];
  count_expect_t         oldest;
  count_expect_t         fresh;
  int                    fails = 0;
  int                    waiting = 0;
  int                    checked = 0;

  assign fail_count_o = fails;
  assign pending_o    = waiting;
  assign checked_o    = checked;

  initial begin
    for (int p = 0; p < ARRAY_DEPTH; p++) shadow_store[p] = '0;
  end

  task automatic report_mismatch(input string what);
    fails++;
    $display("%0t ns  mismatch: %s", $time, what);
  endtask

  // Mark each value on a first pass, then clear the same marks, as the block does.
  function automatic logic [rdc_pkg::COUNT_BITS-1:0] distinct_in_range(
    input int unsigned left,
    input int unsigned right
  );
    int unsigned hits;
    int unsigned last;
    hits = 0;
    last = (right >= ARRAY_DEPTH) ? ARRAY_DEPTH - 1 : right;
    if (left > last) return '0;
    for (int unsigned p = left; p <= last; p++) begin
      if (!seen_mark[shadow_store[p]]) begin
        seen_mark[shadow_store[p]] = 1'b1;
        hits++;
      end
    end
    for (int unsigned p = left; p <= last; p++) seen_mark[shadow_store[p]] = 1'b0;
    return hits[rdc_pkg::COUNT_BITS-1:0];
  endfunction

  // Check the outgoing word first so a word can never match a query taken
  // at the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (waiting == 0) begin
          report_mismatch($sformatf("distinct_count %0d with no query outstanding",
                                    distinct_count_i));
        end else begin
          oldest = expected_counts.pop_front();
          waiting--;
          checked++;
          if (distinct_count_i !== oldest.count) begin
            report_mismatch($sformatf("query [%0d..%0d]: distinct_count %0d, want %0d",
                                      oldest.left, oldest.right, distinct_count_i,
                                      oldest.count));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (command_i == rdc_pkg::CMD_QUERY) begin
          fresh.left  = position_i;
          fresh.right = right_end_i;
          fresh.count = distinct_in_range(position_i, right_end_i);
          expected_counts = {expected_counts, fresh};
          waiting++;
        end else if (position_i < ARRAY_DEPTH) begin
          shadow_store[position_i] = VALUE_BITS'(new_value_i);
        end
      end
    end
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// Top of the range_distinct_count_with_updates bench: clock, reset, set and
// query words with random gaps and stalls, and the verdict. Depends on
// rdc_pkg, the block and rdc_count_checker.
module tb;

  localparam int unsigned DEPTH        = rdc_pkg::ARRAY_DEPTH_DEF;
  localparam int unsigned RANDOM_ITEMS = 268;
  localparam int unsigned CYCLE_LIMIT  = 3_000_000;
  localparam int unsigned DRAIN_CYCLES = 2 * DEPTH + 16;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic                            command = rdc_pkg::CMD_SET;
  logic [rdc_pkg::POS_BITS-1:0]    position = '0;
  logic [rdc_pkg::POS_BITS-1:0]    right_end = '0;
  logic [rdc_pkg::NEWV_BITS-1:0]   new_value = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [rdc_pkg::COUNT_BITS-1:0]  distinct_count;

  int          fail_count;
  int          pending;
  int          checked;
  int unsigned cycles = 0;

  bit          written [DEPTH];
  int unsigned frontier = 0;
  int unsigned calm_in = 0;
  int unsigned calm_out = 0;
  int unsigned set_words = 0;
  int unsigned query_words = 0;
  int unsigned reversed_words = 0;
  int unsigned widest = 0;

  always #6 clk = ~clk;

  range_distinct_count_with_updates dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .command_i        (command),
    .position_i       (position),
    .right_end_i      (right_end),
    .new_value_i      (new_value),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .distinct_count_o (distinct_count)
  );

  rdc_count_checker count_chk (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .command_i        (command),
    .position_i       (position),
    .right_end_i      (right_end),
    .new_value_i      (new_value),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .distinct_count_i (distinct_count),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .checked_o        (checked)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d counts outstanding", cycles, pending);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Idle draw with occasional stretches of back-to-back words.
  function automatic int unsigned draw_wait(inout int unsigned calm);
    if (calm != 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 11) == 0) calm = $urandom_range(8, 30);
    return $urandom_range(0, 15);
  endfunction

  // Mostly a small pool so ranges hold repeats; some sit at the top, the rest span all 16 bits.
  function automatic logic [15:0] draw_value();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return 16'($urandom_range(0, 11));
    else if (pick < 8) return 16'hFFFF - 16'($urandom_range(0, 3));
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  // Called at a rising edge; returns at the edge that accepts the word.
  task automatic send_word(input rdc_pkg::cmd_e cmd, input int unsigned pos,
                           input int unsigned re, input logic [15:0] val);
    int unsigned gap;
    gap = draw_wait(calm_in);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    command   <= cmd;
    position  <= pos[rdc_pkg::POS_BITS-1:0];
    right_end <= re[rdc_pkg::POS_BITS-1:0];
    new_value <= val;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic set_value(input int unsigned pos, input logic [15:0] val);
    send_word(rdc_pkg::CMD_SET, pos, $urandom_range(0, DEPTH - 1), val);
    set_words++;
    written[pos] = 1'b1;
    while (frontier < DEPTH && written[frontier]) frontier++;
  endtask

  task automatic ask_range(input int unsigned left, input int unsigned right);
    send_word(rdc_pkg::CMD_QUERY, left, right, 16'($urandom_range(0, 16'hFFFF)));
    query_words++;
    if (left > right) reversed_words++;
    else if (right - left + 1 > widest) widest = right - left + 1;
  endtask

  // Hold the sender until every outstanding count has been returned.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  initial begin : receiver
    int unsigned stall;
    forever begin
      stall = draw_wait(calm_out);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    int unsigned pick;
    int unsigned left;
    int unsigned right;
    int unsigned span;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: both array ends, value extremes, repeats, reversed ranges.
    set_value(0, 16'h0000);
    set_value(DEPTH - 1, 16'hFFFF);
    ask_range(0, 0);
    ask_range(DEPTH - 1, DEPTH - 1);
    ask_range(DEPTH - 1, 0);
    ask_range(1, 0);
    set_value(1, 16'hFFFF);
    set_value(2, 16'h0000);
    set_value(3, 16'hFFFF);
    set_value(4, 16'h5555);
    set_value(5, 16'hAAAA);
    set_value(6, 16'h5555);
    set_value(7, 16'h8001);
    ask_range(0, 7);
    set_value(3, 16'h1234);
    ask_range(0, 7);
    ask_range(2, 5);
    ask_range(7, 7);
    ask_range(5, 4);
    set_value(DEPTH - 2, 16'h7FFF);
    ask_range(DEPTH - 2, DEPTH - 1);

    // Random: grow the loaded prefix, update it, scatter writes, and query ranges
    // inside the prefix or reversed ranges, so no unwritten entry is ever read.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) wait_drained();
      pick = $urandom_range(0, 99);
      if (pick < 30 && frontier < DEPTH) begin
        set_value(frontier, draw_value());
      end else if (pick < 45) begin
        set_value($urandom_range(0, frontier - 1), draw_value());
      end else if (pick < 55) begin
        set_value($urandom_range(0, DEPTH - 1), 16'($urandom_range(0, 16'hFFFF)));
      end else if (pick < 93) begin
        left  = $urandom_range(0, frontier - 1);
        span  = ($urandom_range(0, 7) == 0) ? frontier : 32;
        right = left + $urandom_range(0, span - 1);
        if (right > frontier - 1) right = frontier - 1;
        ask_range(left, right);
      end else begin
        left  = $urandom_range(1, DEPTH - 1);
        right = $urandom_range(0, left - 1);
        ask_range(left, right);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d set words and %0d queries (%0d reversed), widest range %0d",
             set_words, query_words, reversed_words, widest);
    $display("%0d distinct counts compared over a loaded prefix of %0d positions",
             checked, frontier);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
